/* hdl/capture_period_frequency_meter_core_defines.svh */
// Assertion macros shared by the checker of the frequency meter.
// Each macro expects i_clk and i_rst_n to exist where it is used.
`ifndef CAPTURE_PERIOD_FREQUENCY_METER_CORE_DEFINES_SVH
`define CAPTURE_PERIOD_FREQUENCY_METER_CORE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CPFM_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("frequency meter check failed in the same cycle");

// The consequent must hold in the cycle after the antecedent.
`define CPFM_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("frequency meter check failed in the next cycle");

`endif

/* hdl/cpfm_pkg.sv */
`timescale 1ns / 1ps

package cpfm_pkg;

    localparam int CAP_W    = 16;
    localparam int FREQ_W   = 16;
    localparam int RPM_W    = 22;
    localparam int PERIOD_W = 32;
    localparam int REF_W    = 32;
    localparam int OVF_W    = 16;
    localparam int CFG_W    = 32;

    typedef logic [1:0] t_cfg_addr;

    localparam t_cfg_addr CFG_REF_CLOCK = 2'd0;
    localparam t_cfg_addr CFG_MIN_FREQ  = 2'd1;
    localparam t_cfg_addr CFG_MAX_FREQ  = 2'd2;

    localparam logic [REF_W-1:0]  REF_CLOCK_RESET = 32'd500000;
    localparam logic [FREQ_W-1:0] MIN_FREQ_RESET  = 16'd7;
    localparam logic [FREQ_W-1:0] MAX_FREQ_RESET  = 16'd100;

    localparam logic [5:0] RPM_PER_HZ = 6'd60;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_CHECK,
        ST_RESULT
    } t_state;

endpackage

/* hdl/cpfm_intf.sv */
`timescale 1ns / 1ps

interface cpfm_in_if;
    logic                          valid;
    logic                          ready;
    logic                          cmd;
    logic [cpfm_pkg::CAP_W-1:0]    capture_value;

    modport source (output valid, cmd, capture_value, input ready);
    modport sink   (input valid, cmd, capture_value, output ready);
endinterface

interface cpfm_out_if;
    logic                           valid;
    logic                           ready;
    logic [cpfm_pkg::FREQ_W-1:0]    frequency_hz;
    logic [cpfm_pkg::RPM_W-1:0]     speed_rpm;
    logic                           measurement_accepted;
    logic                           clear_counter;
    logic [cpfm_pkg::PERIOD_W-1:0]  period_ticks;

    modport source (output valid, frequency_hz, speed_rpm, measurement_accepted,
                    clear_counter, period_ticks, input ready);
    modport sink   (input valid, frequency_hz, speed_rpm, measurement_accepted,
                    clear_counter, period_ticks, output ready);
endinterface

interface cpfm_cfg_if;
    logic                        valid;
    logic                        ready;
    cpfm_pkg::t_cfg_addr         index;
    logic [cpfm_pkg::CFG_W-1:0]  data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

/* hdl/capture_period_frequency_meter_core.sv */
// Capture period frequency meter.
// Requests arrive on i_in: cmd 1 is a counter overflow tick, cmd 0 is a capture
// carrying the counter value. Every request gives exactly one response on o_out.
// The second capture of a pair computes the period and divides the reference
// clock rate by it; a quotient inside the frequency limits becomes the held
// frequency, and the response asks for the external counter to be cleared.
// Registers are written on i_cfg, which is always ready; write only while idle.
// Overflow ticks, first captures and zero-period second captures pass from idle
// straight to the result state, which loads the output register once it is free.
// A second capture with a nonzero period passes through the divide, check and
// result states: 32 iterations of the restoring divide-and-subtract unit, one
// limit compare and one output load. The sequencer is idle again after the load.
// i_in.ready is high only while the sequencer is idle, so one request is in
// work at a time; a new request can be taken while a response still waits on
// o_out. If the receiver stalls, the finished response holds in the output
// register and the next result waits in its pending stage until o_out drains.
// Synchronous reset loads the register reset values, clears the capture pair
// state, overflow count and held frequency, and empties the output.
`timescale 1ns / 1ps

module capture_period_frequency_meter_core #(
    parameter int COUNTER_BITS = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    cpfm_in_if.sink           i_in,
    cpfm_out_if.source        o_out,
    cpfm_cfg_if.sink          i_cfg
);
    import cpfm_pkg::*;

    localparam int CAP_BITS = (COUNTER_BITS < CAP_W) ? COUNTER_BITS : CAP_W;
    localparam logic [CAP_W-1:0] CAP_MASK = CAP_W'((17'(1) << CAP_BITS) - 17'(1));
    localparam int SH_W  = OVF_W + 32;
    localparam int CNT_W = $clog2(PERIOD_W);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(PERIOD_W - 1);

    t_state r_state, n_state;

    logic [REF_W-1:0]    r_ref_clock;
    logic [FREQ_W-1:0]   r_min_freq;
    logic [FREQ_W-1:0]   r_max_freq;

    logic                r_waiting;
    logic [CAP_W-1:0]    r_first;
    logic [OVF_W-1:0]    r_ovf;
    logic [FREQ_W-1:0]   r_held;

    logic [PERIOD_W-1:0] r_div;
    logic [PERIOD_W-1:0] r_rem;
    logic [PERIOD_W-1:0] r_quo;
    logic [CNT_W-1:0]    r_cnt;

    logic                r_pend_acc;
    logic                r_pend_clr;
    logic [PERIOD_W-1:0] r_pend_period;

    logic                r_out_valid;
    logic [FREQ_W-1:0]   r_out_freq;
    logic [RPM_W-1:0]    r_out_rpm;
    logic                r_out_acc;
    logic                r_out_clr;
    logic [PERIOD_W-1:0] r_out_period;

    logic                w_in_ready;
    logic                w_in_take;
    logic                w_load_out;
    logic                w_quo_ok;
    logic [CAP_W-1:0]    w_cap;
    logic [SH_W-1:0]     w_ovf_sh;
    logic [PERIOD_W-1:0] w_period;
    logic [PERIOD_W+1:0] w_sub;

    assign w_cap    = i_in.capture_value & CAP_MASK;
    assign w_ovf_sh = SH_W'(r_ovf) << COUNTER_BITS;
    assign w_period = PERIOD_W'(w_cap) + w_ovf_sh[PERIOD_W-1:0] - PERIOD_W'(r_first);
    assign w_sub    = {1'b0, r_rem, r_quo[PERIOD_W-1]} - {2'b00, r_div};
    assign w_quo_ok = (r_quo >= PERIOD_W'(r_min_freq)) && (r_quo <= PERIOD_W'(r_max_freq));

    always_comb begin
        w_in_ready = (r_state == ST_IDLE);
        w_in_take  = w_in_ready && i_in.valid;
        w_load_out = (r_state == ST_RESULT) && (!r_out_valid || o_out.ready);
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_in_take) begin
                    if (!i_in.cmd && r_waiting && (w_period != '0)) begin
                        n_state = ST_DIV;
                    end else begin
                        n_state = ST_RESULT;
                    end
                end
            end
            ST_DIV: begin
                if (r_cnt == CNT_LAST) begin
                    n_state = ST_CHECK;
                end
            end
            ST_CHECK: begin
                n_state = ST_RESULT;
            end
            ST_RESULT: begin
                if (w_load_out) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ref_clock <= REF_CLOCK_RESET;
            r_min_freq  <= MIN_FREQ_RESET;
            r_max_freq  <= MAX_FREQ_RESET;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                CFG_REF_CLOCK: r_ref_clock <= i_cfg.data[REF_W-1:0];
                CFG_MIN_FREQ:  r_min_freq  <= i_cfg.data[FREQ_W-1:0];
                CFG_MAX_FREQ:  r_max_freq  <= i_cfg.data[FREQ_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_waiting <= 1'b0;
            r_first   <= '0;
            r_ovf     <= '0;
            r_held    <= '0;
        end else if (w_in_take) begin
            if (i_in.cmd) begin
                r_ovf <= r_ovf + OVF_W'(1);
            end else if (!r_waiting) begin
                r_first   <= w_cap;
                r_ovf     <= '0;
                r_waiting <= 1'b1;
            end else begin
                r_waiting <= 1'b0;
            end
        end else if ((r_state == ST_CHECK) && w_quo_ok) begin
            r_held <= r_quo[FREQ_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                if (w_in_take) begin
                    r_pend_acc    <= 1'b0;
                    r_pend_clr    <= !i_in.cmd && r_waiting;
                    r_pend_period <= (!i_in.cmd && r_waiting) ? w_period : '0;
                    r_div         <= w_period;
                    r_rem         <= '0;
                    r_quo         <= r_ref_clock;
                    r_cnt         <= '0;
                end
            end
            ST_DIV: begin
                r_cnt <= r_cnt + CNT_W'(1);
                r_quo <= {r_quo[PERIOD_W-2:0], ~w_sub[PERIOD_W+1]};
                if (!w_sub[PERIOD_W+1]) begin
                    r_rem <= w_sub[PERIOD_W-1:0];
                end else begin
                    r_rem <= {r_rem[PERIOD_W-2:0], r_quo[PERIOD_W-1]};
                end
            end
            ST_CHECK: begin
                r_pend_acc <= w_quo_ok;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load_out) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load_out) begin
            r_out_freq   <= r_held;
            r_out_rpm    <= RPM_W'(r_held) * RPM_W'(RPM_PER_HZ);
            r_out_acc    <= r_pend_acc;
            r_out_clr    <= r_pend_clr;
            r_out_period <= r_pend_period;
        end
    end

    assign i_in.ready                 = w_in_ready;
    assign i_cfg.ready                = 1'b1;
    assign o_out.valid                = r_out_valid;
    assign o_out.frequency_hz         = r_out_freq;
    assign o_out.speed_rpm            = r_out_rpm;
    assign o_out.measurement_accepted = r_out_acc;
    assign o_out.clear_counter        = r_out_clr;
    assign o_out.period_ticks         = r_out_period;

endmodule

/* hdl/cpfm_checker.sv */
`timescale 1ns / 1ps
`include "capture_period_frequency_meter_core_defines.svh"

module cpfm_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_in_valid,
    input logic                           i_in_ready,
    input logic                           i_out_valid,
    input logic                           i_out_ready,
    input logic [cpfm_pkg::FREQ_W-1:0]    i_freq,
    input logic [cpfm_pkg::RPM_W-1:0]     i_rpm,
    input logic                           i_acc,
    input logic                           i_clr,
    input logic [cpfm_pkg::PERIOD_W-1:0]  i_period
);
    import cpfm_pkg::*;

    `CPFM_ASSERT_NEXT(a_out_hold, i_out_valid && !i_out_ready, i_out_valid && $stable(i_freq) && $stable(i_rpm) && $stable(i_acc) && $stable(i_clr) && $stable(i_period))
    `CPFM_ASSERT_SAME(a_acc_needs_clr, i_out_valid && i_acc, i_clr)
    `CPFM_ASSERT_SAME(a_rpm_matches, i_out_valid, i_rpm == RPM_W'(i_freq) * RPM_W'(RPM_PER_HZ))
    `CPFM_ASSERT_SAME(a_period_only_on_pair, i_out_valid && !i_clr, i_period == '0)
    `CPFM_ASSERT_NEXT(a_busy_after_take, i_in_valid && i_in_ready, !i_in_ready)

endmodule

bind capture_period_frequency_meter_core cpfm_checker u_cpfm_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_freq      (o_out.frequency_hz),
    .i_rpm       (o_out.speed_rpm),
    .i_acc       (o_out.measurement_accepted),
    .i_clr       (o_out.clear_counter),
    .i_period    (o_out.period_ticks)
);

/* sim/capture_period_frequency_meter_core_test.sv */
`timescale 1ns / 1ps

module capture_period_frequency_meter_core_test;
    import cpfm_pkg::*;

    localparam int COUNTER_BITS   = 16;
    localparam logic CMD_CAPTURE  = 1'b0;
    localparam logic CMD_OVERFLOW = 1'b1;
    localparam int IDLE_PERCENT   = 21;
    localparam int RX_HOLD_CYCLES = 300;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DRAIN_CYCLES   = 40;
    localparam int PHASE_ITEMS    = 200;

    typedef struct {
        logic [FREQ_W-1:0]   frequency_hz;
        logic [RPM_W-1:0]    speed_rpm;
        logic                accepted;
        logic                clear_counter;
        logic [PERIOD_W-1:0] period_ticks;
    } t_reading;

    logic i_clk = 1'b0;
    logic i_rst_n;

    cpfm_in_if  in_if();
    cpfm_out_if out_if();
    cpfm_cfg_if cfg_if();

    capture_period_frequency_meter_core #(
        .COUNTER_BITS(COUNTER_BITS)
    ) DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if),
        .i_cfg   (cfg_if)
    );

    // Model state of the meter and its registers.
    logic               second_pending;
    logic [CAP_W-1:0]   first_cap;
    logic [OVF_W-1:0]   ovf_count;
    logic [FREQ_W-1:0]  held_freq;
    logic [REF_W-1:0]   cfg_ref_clock;
    logic [FREQ_W-1:0]  cfg_min_freq;
    logic [FREQ_W-1:0]  cfg_max_freq;

    t_reading expected_readings[$];
    int  mismatch_count = 0;
    int  items_sent = 0;
    int  quiet_cycles = 0;
    bit  idle_on = 1'b1;
    bit  rx_hold = 1'b0;
    event rx_hold_start;

    always begin
        i_clk = 1'b0;
        #1;
        i_clk = 1'b1;
        #1;
    end

    function automatic void meter_predict(logic cmd, logic [CAP_W-1:0] cap);
        t_reading            r;
        logic [PERIOD_W-1:0] span;
        logic [REF_W-1:0]    quot;
        r = '{default: '0};
        if (cmd == CMD_OVERFLOW) begin
            ovf_count = ovf_count + OVF_W'(1);
        end else if (!second_pending) begin
            first_cap = cap;
            ovf_count = '0;
            second_pending = 1'b1;
        end else begin
            span = PERIOD_W'(cap) + (PERIOD_W'(ovf_count) << COUNTER_BITS)
                   - PERIOD_W'(first_cap);
            if (span != '0) begin
                quot = cfg_ref_clock / span;
                if (quot >= REF_W'(cfg_min_freq) && quot <= REF_W'(cfg_max_freq)) begin
                    held_freq = quot[FREQ_W-1:0];
                    r.accepted = 1'b1;
                end
            end
            r.clear_counter = 1'b1;
            r.period_ticks = span;
            second_pending = 1'b0;
        end
        r.frequency_hz = held_freq;
        r.speed_rpm = RPM_W'(held_freq) * RPM_W'(RPM_PER_HZ);
        expected_readings.push_back(r);
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        mismatch_count++;
        $display("mismatch at %0t: %s got %0d expected %0d", $time, what, got, want);
    endtask

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic send_item(logic cmd, logic [CAP_W-1:0] cap);
        while (idle_on && $urandom_range(0, 99) < IDLE_PERCENT) begin
            in_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_if.valid <= 1'b1;
        in_if.cmd <= cmd;
        in_if.capture_value <= cap;
        @(posedge i_clk);
        while (!in_if.ready) begin
            @(posedge i_clk);
        end
        meter_predict(cmd, cap);
        items_sent++;
        @(negedge i_clk);
    endtask

    task automatic measure_period(logic [CAP_W-1:0] first, int unsigned ticks,
                                  logic [CAP_W-1:0] second);
        send_item(CMD_CAPTURE, first);
        repeat (ticks) begin
            send_item(CMD_OVERFLOW, CAP_W'($urandom));
        end
        send_item(CMD_CAPTURE, second);
    endtask

    task automatic drain();
        in_if.valid <= 1'b0;
        while (expected_readings.size() != 0) begin
            @(negedge i_clk);
        end
        @(negedge i_clk);
    endtask

    task automatic set_limits(logic [REF_W-1:0] clock_rate, logic [FREQ_W-1:0] lo,
                              logic [FREQ_W-1:0] hi);
        t_cfg_addr        idx [3];
        logic [CFG_W-1:0] val [3];
        idx = '{CFG_REF_CLOCK, CFG_MIN_FREQ, CFG_MAX_FREQ};
        val = '{CFG_W'(clock_rate), CFG_W'(lo), CFG_W'(hi)};
        for (int k = 0; k < 3; k++) begin
            cfg_if.valid <= 1'b1;
            cfg_if.index <= idx[k];
            cfg_if.data <= val[k];
            @(posedge i_clk);
            while (!cfg_if.ready) begin
                @(posedge i_clk);
            end
            case (idx[k])
                CFG_REF_CLOCK: begin
                    cfg_ref_clock = val[k][REF_W-1:0];
                end
                CFG_MIN_FREQ: begin
                    cfg_min_freq = val[k][FREQ_W-1:0];
                end
                CFG_MAX_FREQ: begin
                    cfg_max_freq = val[k][FREQ_W-1:0];
                end
                default: begin
                end
            endcase
            @(negedge i_clk);
        end
        cfg_if.valid <= 1'b0;
    endtask

    // Mostly capture pairs aimed inside the frequency window, some random pairs,
    // and some stray ticks or lone captures that break the pairing.
    task automatic random_measurement();
        int unsigned         pick;
        int unsigned         want;
        logic [PERIOD_W-1:0] span;
        logic [PERIOD_W-1:0] total;
        logic [CAP_W-1:0]    first;
        pick = $urandom_range(0, 99);
        first = CAP_W'($urandom);
        if (pick < 60) begin
            if (cfg_min_freq <= cfg_max_freq) begin
                want = $urandom_range(cfg_max_freq, cfg_min_freq);
            end else begin
                want = $urandom_range(1, 1000);
            end
            if (want == 0) begin
                want = 1;
            end
            span = cfg_ref_clock / want;
            if (span != '0 && span < (PERIOD_W'(64) << COUNTER_BITS)) begin
                total = PERIOD_W'(first) + span;
                measure_period(first, total >> COUNTER_BITS, total[CAP_W-1:0]);
            end else begin
                measure_period(first, $urandom_range(0, 3), CAP_W'($urandom));
            end
        end else if (pick < 85) begin
            measure_period(first, $urandom_range(0, 3), CAP_W'($urandom));
        end else begin
            send_item(1'($urandom), first);
        end
    endtask

    task automatic test_directed_defaults();
        send_item(CMD_OVERFLOW, 16'hFFFF);
        measure_period(16'h0000, 0, 16'hFFFF);
        measure_period(16'hFFFF, 1, 16'h0000);
        measure_period(16'h1234, 0, 16'h1234);
        measure_period(16'h8000, 0, 16'h9388);
        measure_period(16'h8000, 0, 16'h9356);
        measure_period(16'hFFFF, 0, 16'h0000);
        measure_period(16'hC000, 2, 16'h4000);
    endtask

    task automatic test_reference_clock_zero();
        drain();
        set_limits('0, 16'd0, 16'd100);
        measure_period(16'h0100, 0, 16'h0200);
        drain();
        set_limits('0, MIN_FREQ_RESET, MAX_FREQ_RESET);
        measure_period(16'h0100, 0, 16'h0200);
        drain();
        set_limits(32'd1, 16'd0, 16'd0);
        measure_period(16'h0100, 0, 16'h0101);
        measure_period(16'h0100, 0, 16'h0102);
    endtask

    task automatic test_inverted_limits();
        drain();
        set_limits(REF_CLOCK_RESET, 16'd60, 16'd40);
        measure_period(16'h0000, 0, 16'd10000);
        measure_period(16'h0000, 0, 16'd5000);
        drain();
        set_limits(REF_CLOCK_RESET, 16'hFFFF, 16'h0000);
        measure_period(16'h0000, 0, 16'd10000);
    endtask

    task automatic test_config_extremes();
        drain();
        set_limits(32'hFFFF_FFFF, 16'h0000, 16'hFFFF);
        measure_period(16'h0000, 1, 16'h0000);
        measure_period(16'h0000, 0, 16'hFFFF);
    endtask

    task automatic test_backpressure();
        drain();
        set_limits(REF_CLOCK_RESET, MIN_FREQ_RESET, MAX_FREQ_RESET);
        -> rx_hold_start;
        repeat (6) begin
            random_measurement();
        end
    endtask

    task automatic test_random_traffic();
        int stop_at;
        for (int phase = 0; phase < 5; phase++) begin
            drain();
            case (phase)
                0: set_limits(REF_CLOCK_RESET, MIN_FREQ_RESET, MAX_FREQ_RESET);
                1: set_limits(32'd170000000, 16'd100, 16'd340);
                2: set_limits(REF_W'($urandom), FREQ_W'($urandom_range(0, 200)),
                              FREQ_W'($urandom_range(200, 65535)));
                3: set_limits(32'd1, 16'd0, 16'd0);
                default: set_limits(REF_CLOCK_RESET, 16'd50, 16'd20);
            endcase
            idle_on = (phase != 1);
            stop_at = items_sent + PHASE_ITEMS;
            while (items_sent < stop_at) begin
                random_measurement();
            end
        end
        idle_on = 1'b1;
    endtask

    initial begin
        out_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            out_if.ready <= !rx_hold && (!idle_on || $urandom_range(0, 99) >= IDLE_PERCENT);
        end
    end

    always begin
        @(rx_hold_start);
        rx_hold = 1'b1;
        repeat (RX_HOLD_CYCLES) @(negedge i_clk);
        rx_hold = 1'b0;
    end

    always @(posedge i_clk) begin
        t_reading want;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            if (expected_readings.size() == 0) begin
                report_mismatch("response without request", 1, 0);
            end else begin
                want = expected_readings.pop_front();
                if (out_if.frequency_hz !== want.frequency_hz) begin
                    report_mismatch("frequency_hz", out_if.frequency_hz, want.frequency_hz);
                end
                if (out_if.speed_rpm !== want.speed_rpm) begin
                    report_mismatch("speed_rpm", out_if.speed_rpm, want.speed_rpm);
                end
                if (out_if.measurement_accepted !== want.accepted) begin
                    report_mismatch("measurement_accepted", out_if.measurement_accepted,
                                    want.accepted);
                end
                if (out_if.clear_counter !== want.clear_counter) begin
                    report_mismatch("clear_counter", out_if.clear_counter,
                                    want.clear_counter);
                end
                if (out_if.period_ticks !== want.period_ticks) begin
                    report_mismatch("period_ticks", out_if.period_ticks, want.period_ticks);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)
                || (cfg_if.valid && cfg_if.ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles == WATCHDOG_LIMIT) begin
                $display("[capture_period_frequency_meter_core] ERROR");
                $finish;
            end
        end
    end

    initial begin
        in_if.valid = 1'b0;
        in_if.cmd = CMD_CAPTURE;
        in_if.capture_value = '0;
        cfg_if.valid = 1'b0;
        cfg_if.index = CFG_REF_CLOCK;
        cfg_if.data = '0;
        i_rst_n = 1'b0;
        second_pending = 1'b0;
        first_cap = '0;
        ovf_count = '0;
        held_freq = '0;
        cfg_ref_clock = REF_CLOCK_RESET;
        cfg_min_freq = MIN_FREQ_RESET;
        cfg_max_freq = MAX_FREQ_RESET;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_directed_defaults();
        test_reference_clock_zero();
        test_inverted_limits();
        test_config_extremes();
        test_backpressure();
        test_random_traffic();

        drain();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (expected_readings.size() != 0) begin
            report_mismatch("requests left without response", expected_readings.size(), 0);
        end
        if (mismatch_count == 0) begin
            $display("[capture_period_frequency_meter_core] OK");
        end else begin
            $display("[capture_period_frequency_meter_core] ERROR");
        end
        $finish;
    end

endmodule

/* sim.f */
+incdir+hdl
hdl/cpfm_pkg.sv
hdl/cpfm_intf.sv
hdl/capture_period_frequency_meter_core.sv
hdl/cpfm_checker.sv
sim/capture_period_frequency_meter_core_test.sv
